// File: rtl/bqw_pkg.sv
package bqw_pkg;

  // Pixel coordinate and fixed-point format
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 12;

  // Register formats
  localparam int LANE_W = 16;
  localparam int INV_W  = 32;
  localparam int REG_W  = 64;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_OFFSET = 3'd0;
  localparam logic [IDX_W-1:0] REG_RANGE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_INV    = 3'd2;
  localparam logic [IDX_W-1:0] REG_C_TL   = 3'd3;
  localparam logic [IDX_W-1:0] REG_C_TR   = 3'd4;
  localparam logic [IDX_W-1:0] REG_C_BL   = 3'd5;
  localparam logic [IDX_W-1:0] REG_C_BR   = 3'd6;

  // Register reset values
  localparam logic [31:0]      OFFSET_RST = 32'h0000_0000;
  localparam logic [31:0]      RANGE_RST  = 32'h0001_0001;
  localparam logic [REG_W-1:0] INV_RST    = 64'h8000_0000_8000_0000;
  localparam logic [31:0]      C_TL_RST   = 32'h0000_0000;
  localparam logic [31:0]      C_TR_RST   = 32'h0000_1000;
  localparam logic [31:0]      C_BL_RST   = 32'h1000_0000;
  localparam logic [31:0]      C_BR_RST   = 32'h1000_1000;

  // Datapath widths
  localparam int PROD_W  = COORD_BITS + INV_W;          // d * inv
  localparam int NORM_SH = 31 - FRAC_BITS;              // Q1.31 -> F fraction bits
  localparam int N_W     = FRAC_BITS + 3;               // saturated normalized value
  localparam int PP_W    = 2 * N_W;                     // nx * ny
  localparam int P_W     = PP_W - FRAC_BITS;            // rounded bilinear term
  localparam int A_W     = LANE_W + 2;                  // c0 - c1 - c2 + c3
  localparam int B_W     = LANE_W + 1;                  // c1 - c0, c2 - c0
  localparam int PA_W    = P_W + 1 + A_W;
  localparam int NB_W    = N_W + 1 + B_W;
  localparam int S_W     = P_W + A_W + 2;               // polynomial sum
  localparam int LO_W    = 2 * FRAC_BITS;               // low split of s
  localparam int HI_W    = S_W - LO_W;                  // high split of s
  localparam int LP_W    = LO_W + COORD_BITS;
  localparam int HP_W    = HI_W + COORD_BITS + 1;
  localparam int V_W     = S_W + COORD_BITS + 1;
  localparam int R_W     = V_W - 2 * FRAC_BITS;

  // Pipeline depths of the two halves
  localparam int NORM_STG = 4;
  localparam int MAP_STG  = 4;

  // Decoded configuration, per axis (0 = x, 1 = y)
  typedef struct packed {
    logic [1:0][COORD_BITS-1:0] org;
    logic [1:0][COORD_BITS-1:0] rng;
    logic [1:0][INV_W-1:0]      inv;
    logic [1:0][A_W-1:0]        a;
    logic [1:0][B_W-1:0]        b;
    logic [1:0][B_W-1:0]        c;
    logic [1:0][LANE_W-1:0]     c0;
  } cfg_t;

  // Item handed from the normalizer to the mapper
  typedef struct packed {
    logic [1:0][COORD_BITS-1:0] pt;
    logic                       in_rect;
    logic [1:0][N_W-1:0]        n;
    logic [PP_W-1:0]            pp;
  } norm_item_t;

endpackage

// File: rtl/bqw_if.sv
interface bqw_in_if;
  logic                             valid;
  logic                             ready;
  logic [bqw_pkg::COORD_BITS-1:0]   point_x;
  logic [bqw_pkg::COORD_BITS-1:0]   point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface bqw_out_if;
  logic                             valid;
  logic                             ready;
  logic [bqw_pkg::COORD_BITS-1:0]   warped_x;
  logic [bqw_pkg::COORD_BITS-1:0]   warped_y;
  logic                             inside_res;
  logic                             clamped;

  modport source (output valid, output warped_x, output warped_y, output inside_res,
                  output clamped, input ready);
  modport sink   (input valid, input warped_x, input warped_y, input inside_res,
                  input clamped, output ready);
endinterface

// File: rtl/bilinear_quad_point_warp_core.sv
// Bilinear corner-pin point warp. Each accepted item is one pixel point; a point
// inside the rectangle [offset, offset+range] is normalized with the reciprocal
// registers, mapped through the bilinear patch spanned by the four corner
// registers, scaled back, rounded and clamped to pixel range; any other point
// comes out unchanged with inside_res and clamped low. The block takes one item
// per clock while the output is not stalled and returns one result per item: a
// four-stage normalizer (range test, reciprocal multiply, round and saturate,
// nx*ny product) feeds a four-stage mapper (coefficient products, polynomial
// sum, split range multiply, offset add with rounding and clamp). Every stage
// holds its item while the output is stalled and fills behind a stall.
// Configuration writes take effect for items accepted at the clock edge after
// the write and later; write only while no item is in flight.
module bilinear_quad_point_warp_core (
  input  logic                        clk,
  input  logic                        rst_n,
  bqw_in_if.sink                      in_item,
  bqw_out_if.source                   out_item,
  input  logic                        cfg_we,
  input  logic [bqw_pkg::IDX_W-1:0]   cfg_index,
  input  logic [bqw_pkg::REG_W-1:0]   cfg_data
);

  bqw_pkg::cfg_t                       cfg;
  bqw_pkg::norm_item_t                 mid_item;
  logic                                mid_valid;
  logic                                mid_ready;
  logic [1:0][bqw_pkg::COORD_BITS-1:0] in_pt;
  logic [1:0][bqw_pkg::COORD_BITS-1:0] out_pt;
  logic                                in_ready;
  logic                                out_valid;
  logic                                out_inside;
  logic                                out_clamped;

  assign in_pt = {in_item.point_y, in_item.point_x};

  bqw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bqw_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_item.valid),
    .in_ready (in_ready),
    .in_pt    (in_pt),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_item  (mid_item)
  );

  bqw_map u_map (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .up_valid    (mid_valid),
    .up_ready    (mid_ready),
    .up_item     (mid_item),
    .out_valid   (out_valid),
    .out_ready   (out_item.ready),
    .out_pt      (out_pt),
    .out_inside  (out_inside),
    .out_clamped (out_clamped)
  );

  assign in_item.ready       = in_ready;
  assign out_item.valid      = out_valid;
  assign out_item.warped_x   = out_pt[0];
  assign out_item.warped_y   = out_pt[1];
  assign out_item.inside_res = out_inside;
  assign out_item.clamped    = out_clamped;

endmodule

// File: rtl/bqw_cfg.sv
module bqw_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bqw_pkg::IDX_W-1:0]     cfg_index,
  input  logic [bqw_pkg::REG_W-1:0]     cfg_data,
  output bqw_pkg::cfg_t                 cfg
);

  logic [31:0]               offset_r;
  logic [31:0]               range_r;
  logic [bqw_pkg::REG_W-1:0] inv_r;
  logic [31:0]               corner_r [4];

  logic [1:0][bqw_pkg::A_W-1:0]    a_r;
  logic [1:0][bqw_pkg::B_W-1:0]    b_r;
  logic [1:0][bqw_pkg::B_W-1:0]    c_r;
  logic [1:0][bqw_pkg::LANE_W-1:0] c0_r;

  logic [1:0][bqw_pkg::A_W-1:0]    a_nxt;
  logic [1:0][bqw_pkg::B_W-1:0]    b_nxt;
  logic [1:0][bqw_pkg::B_W-1:0]    c_nxt;

  // Write the register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= bqw_pkg::OFFSET_RST;
      range_r     <= bqw_pkg::RANGE_RST;
      inv_r       <= bqw_pkg::INV_RST;
      corner_r[0] <= bqw_pkg::C_TL_RST;
      corner_r[1] <= bqw_pkg::C_TR_RST;
      corner_r[2] <= bqw_pkg::C_BL_RST;
      corner_r[3] <= bqw_pkg::C_BR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bqw_pkg::REG_OFFSET: offset_r    <= cfg_data[31:0];
        bqw_pkg::REG_RANGE:  range_r     <= cfg_data[31:0];
        bqw_pkg::REG_INV:    inv_r       <= cfg_data;
        bqw_pkg::REG_C_TL:   corner_r[0] <= cfg_data[31:0];
        bqw_pkg::REG_C_TR:   corner_r[1] <= cfg_data[31:0];
        bqw_pkg::REG_C_BL:   corner_r[2] <= cfg_data[31:0];
        bqw_pkg::REG_C_BR:   corner_r[3] <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Form the bilinear coefficients per axis from the corner lanes
  always_comb begin
    logic signed [bqw_pkg::LANE_W-1:0] l0, l1, l2, l3;
    for (int ax = 0; ax < 2; ax++) begin
      l0 = $signed(corner_r[0][ax*bqw_pkg::LANE_W +: bqw_pkg::LANE_W]);
      l1 = $signed(corner_r[1][ax*bqw_pkg::LANE_W +: bqw_pkg::LANE_W]);
      l2 = $signed(corner_r[2][ax*bqw_pkg::LANE_W +: bqw_pkg::LANE_W]);
      l3 = $signed(corner_r[3][ax*bqw_pkg::LANE_W +: bqw_pkg::LANE_W]);
      a_nxt[ax] = bqw_pkg::A_W'(l0) - bqw_pkg::A_W'(l1) - bqw_pkg::A_W'(l2)
                + bqw_pkg::A_W'(l3);
      b_nxt[ax] = bqw_pkg::B_W'(l1) - bqw_pkg::B_W'(l0);
      c_nxt[ax] = bqw_pkg::B_W'(l2) - bqw_pkg::B_W'(l0);
    end
  end

  // Hold the coefficients in registers; they settle in the cycle after the corner registers change
  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    c_r  <= c_nxt;
    c0_r <= {corner_r[0][2*bqw_pkg::LANE_W-1:bqw_pkg::LANE_W],
             corner_r[0][bqw_pkg::LANE_W-1:0]};
  end

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      cfg.org[ax] = offset_r[ax*bqw_pkg::LANE_W +: bqw_pkg::COORD_BITS];
      cfg.rng[ax] = range_r[ax*bqw_pkg::LANE_W +: bqw_pkg::COORD_BITS];
      cfg.inv[ax] = inv_r[ax*bqw_pkg::INV_W +: bqw_pkg::INV_W];
    end
    cfg.a  = a_r;
    cfg.b  = b_r;
    cfg.c  = c_r;
    cfg.c0 = c0_r;
  end

endmodule

// File: rtl/bqw_norm.sv
module bqw_norm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bqw_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0][bqw_pkg::COORD_BITS-1:0] in_pt,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output bqw_pkg::norm_item_t               dn_item
);

  localparam int LAST = bqw_pkg::NORM_STG - 1;

  logic [LAST:0] vld_r;
  logic [LAST:0] adv;

  logic [1:0][bqw_pkg::COORD_BITS-1:0] pt_r [bqw_pkg::NORM_STG];
  logic [LAST:0]                       inside_r;

  logic [1:0][bqw_pkg::COORD_BITS-1:0] d_r;
  logic [1:0][bqw_pkg::PROD_W-1:0]     prod_r;
  logic [1:0][bqw_pkg::N_W-1:0]        n_r;
  logic [1:0][bqw_pkg::N_W-1:0]        n3_r;
  logic [bqw_pkg::PP_W-1:0]            pp_r;

  logic                                inside_nxt;
  logic [1:0][bqw_pkg::COORD_BITS-1:0] d_nxt;
  logic [1:0][bqw_pkg::PROD_W-1:0]     prod_nxt;
  logic [1:0][bqw_pkg::N_W-1:0]        n_nxt;

  // A stage loads when it is empty or its contents move on
  always_comb begin
    adv[LAST] = !vld_r[LAST] || dn_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 0: rectangle test and offset removal
  always_comb begin
    logic ge, le;
    inside_nxt = 1'b1;
    for (int ax = 0; ax < 2; ax++) begin
      ge = in_pt[ax] >= cfg.org[ax];
      le = {1'b0, in_pt[ax]} <= ({1'b0, cfg.org[ax]} + {1'b0, cfg.rng[ax]});
      inside_nxt = inside_nxt && ge && le;
      d_nxt[ax] = in_pt[ax] - cfg.org[ax];
    end
  end

  // Stage 1: multiply by the reciprocal range
  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      prod_nxt[ax] = bqw_pkg::PROD_W'(d_r[ax]) * bqw_pkg::PROD_W'(cfg.inv[ax]);
    end
  end

  // Stage 2: round to F fraction bits and saturate
  always_comb begin
    logic [bqw_pkg::PROD_W:0] rnd;
    logic [bqw_pkg::PROD_W-bqw_pkg::NORM_SH:0] full;
    for (int ax = 0; ax < 2; ax++) begin
      rnd  = {1'b0, prod_r[ax]}
           + ((bqw_pkg::PROD_W+1)'(1) << (bqw_pkg::NORM_SH - 1));
      full = rnd[bqw_pkg::PROD_W:bqw_pkg::NORM_SH];
      if (|full[bqw_pkg::PROD_W-bqw_pkg::NORM_SH:bqw_pkg::N_W]) begin
        n_nxt[ax] = '1;
      end else begin
        n_nxt[ax] = full[bqw_pkg::N_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pt_r[0]     <= in_pt;
      inside_r[0] <= inside_nxt;
      d_r         <= d_nxt;
    end
    if (adv[1]) begin
      pt_r[1]     <= pt_r[0];
      inside_r[1] <= inside_r[0];
      prod_r      <= prod_nxt;
    end
    if (adv[2]) begin
      pt_r[2]     <= pt_r[1];
      inside_r[2] <= inside_r[1];
      n_r         <= n_nxt;
    end
    // Stage 3: product of the normalized coordinates
    if (adv[3]) begin
      pt_r[3]     <= pt_r[2];
      inside_r[3] <= inside_r[2];
      n3_r        <= n_r;
      pp_r        <= bqw_pkg::PP_W'(n_r[0]) * bqw_pkg::PP_W'(n_r[1]);
    end
  end

  assign dn_valid        = vld_r[LAST];
  assign dn_item.pt      = pt_r[LAST];
  assign dn_item.in_rect = inside_r[LAST];
  assign dn_item.n       = n3_r;
  assign dn_item.pp      = pp_r;

endmodule

// File: rtl/bqw_map.sv
module bqw_map (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bqw_pkg::cfg_t                       cfg,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  bqw_pkg::norm_item_t                 up_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0][bqw_pkg::COORD_BITS-1:0] out_pt,
  output logic                                out_inside,
  output logic                                out_clamped
);

  localparam int LAST = bqw_pkg::MAP_STG - 1;

  logic [LAST:0] vld_r;
  logic [LAST:0] adv;

  logic [1:0][bqw_pkg::COORD_BITS-1:0] pt_r [LAST];
  logic [LAST-1:0]                     inside_r;

  logic signed [bqw_pkg::PA_W-1:0] pa_r [2];
  logic signed [bqw_pkg::NB_W-1:0] nb_r [2];
  logic signed [bqw_pkg::NB_W-1:0] nc_r [2];
  logic signed [bqw_pkg::S_W-1:0]  s_r  [2];
  logic        [bqw_pkg::LP_W-1:0] lp_r [2];
  logic signed [bqw_pkg::HP_W-1:0] hp_r [2];

  logic signed [bqw_pkg::PA_W-1:0] pa_nxt [2];
  logic signed [bqw_pkg::NB_W-1:0] nb_nxt [2];
  logic signed [bqw_pkg::NB_W-1:0] nc_nxt [2];
  logic signed [bqw_pkg::S_W-1:0]  s_nxt  [2];
  logic        [bqw_pkg::LP_W-1:0] lp_nxt [2];
  logic signed [bqw_pkg::HP_W-1:0] hp_nxt [2];

  logic [1:0][bqw_pkg::COORD_BITS-1:0] res_nxt;
  logic [1:0]                          sat_nxt;
  logic [bqw_pkg::P_W-1:0]             p;

  logic [1:0][bqw_pkg::COORD_BITS-1:0] out_pt_r;
  logic                                out_inside_r;
  logic                                out_clamped_r;

  // A stage loads when it is empty or its contents move on
  always_comb begin
    adv[LAST] = !vld_r[LAST] || out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign up_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= up_valid;
      end
      for (int k = 1; k <= LAST; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 0: round the bilinear term and form the three products per axis
  always_comb begin
    logic [bqw_pkg::PP_W:0] pp_rnd;
    pp_rnd = {1'b0, up_item.pp} + ((bqw_pkg::PP_W+1)'(1) << (bqw_pkg::FRAC_BITS - 1));
    p      = pp_rnd[bqw_pkg::FRAC_BITS +: bqw_pkg::P_W];
    for (int ax = 0; ax < 2; ax++) begin
      pa_nxt[ax] = $signed({1'b0, p}) * $signed(cfg.a[ax]);
      nb_nxt[ax] = $signed({1'b0, up_item.n[0]}) * $signed(cfg.b[ax]);
      nc_nxt[ax] = $signed({1'b0, up_item.n[1]}) * $signed(cfg.c[ax]);
    end
  end

  // Stage 1: sum the polynomial terms
  always_comb begin
    logic signed [bqw_pkg::LANE_W-1:0] c0;
    for (int ax = 0; ax < 2; ax++) begin
      c0 = $signed(cfg.c0[ax]);
      s_nxt[ax] = bqw_pkg::S_W'(pa_r[ax]) + bqw_pkg::S_W'(nb_r[ax])
                + bqw_pkg::S_W'(nc_r[ax])
                + (bqw_pkg::S_W'(c0) <<< bqw_pkg::FRAC_BITS);
    end
  end

  // Stage 2: scale by range, split into a low and a high partial product
  always_comb begin
    logic [bqw_pkg::LO_W-1:0] lo;
    logic [bqw_pkg::HI_W-1:0] hi;
    for (int ax = 0; ax < 2; ax++) begin
      lo = s_r[ax][bqw_pkg::LO_W-1:0];
      hi = s_r[ax][bqw_pkg::S_W-1:bqw_pkg::LO_W];
      lp_nxt[ax] = bqw_pkg::LP_W'(lo) * bqw_pkg::LP_W'(cfg.rng[ax]);
      hp_nxt[ax] = $signed(hi) * $signed({1'b0, cfg.rng[ax]});
    end
  end

  // Stage 3: add offset, round to nearest pixel, clamp
  always_comb begin
    logic signed [bqw_pkg::V_W-1:0] v;
    logic signed [bqw_pkg::R_W-1:0] r;
    for (int ax = 0; ax < 2; ax++) begin
      v = (bqw_pkg::V_W'(hp_r[ax]) <<< bqw_pkg::LO_W)
        + $signed(bqw_pkg::V_W'(lp_r[ax]))
        + $signed(bqw_pkg::V_W'(cfg.org[ax]) << (2 * bqw_pkg::FRAC_BITS))
        + $signed(bqw_pkg::V_W'(1) << (2 * bqw_pkg::FRAC_BITS - 1));
      r = v[bqw_pkg::V_W-1:2*bqw_pkg::FRAC_BITS];
      if (r[bqw_pkg::R_W-1]) begin
        res_nxt[ax] = '0;
        sat_nxt[ax] = 1'b1;
      end else if (|r[bqw_pkg::R_W-2:bqw_pkg::COORD_BITS]) begin
        res_nxt[ax] = '1;
        sat_nxt[ax] = 1'b1;
      end else begin
        res_nxt[ax] = r[bqw_pkg::COORD_BITS-1:0];
        sat_nxt[ax] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pt_r[0]     <= up_item.pt;
      inside_r[0] <= up_item.in_rect;
      pa_r        <= pa_nxt;
      nb_r        <= nb_nxt;
      nc_r        <= nc_nxt;
    end
    if (adv[1]) begin
      pt_r[1]     <= pt_r[0];
      inside_r[1] <= inside_r[0];
      s_r         <= s_nxt;
    end
    if (adv[2]) begin
      pt_r[2]     <= pt_r[1];
      inside_r[2] <= inside_r[1];
      lp_r        <= lp_nxt;
      hp_r        <= hp_nxt;
    end
    // Pass points outside the rectangle through unchanged
    if (adv[3]) begin
      out_inside_r <= inside_r[2];
      if (inside_r[2]) begin
        out_pt_r      <= res_nxt;
        out_clamped_r <= |sat_nxt;
      end else begin
        out_pt_r      <= pt_r[2];
        out_clamped_r <= 1'b0;
      end
    end
  end

  assign out_valid   = vld_r[LAST];
  assign out_pt      = out_pt_r;
  assign out_inside  = out_inside_r;
  assign out_clamped = out_clamped_r;

endmodule
